/* rtl/point_in_triangle_test_core_assert.svh */
// assertion macros for the point-in-triangle test rtl, included by pit_decide
`ifndef POINT_IN_TRIANGLE_TEST_CORE_ASSERT_SVH
`define POINT_IN_TRIANGLE_TEST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is low
`define PIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PIT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/pit_pkg.sv */
// types and widths shared by the point-in-triangle test pipeline
package pit_pkg;

    // coordinate width and the widths that grow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int SUM_W      = CROSS_W + 1;

    // one query: three vertices and the point
    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_a_x;
        logic signed [COORD_BITS-1:0] vertex_a_y;
        logic signed [COORD_BITS-1:0] vertex_b_x;
        logic signed [COORD_BITS-1:0] vertex_b_y;
        logic signed [COORD_BITS-1:0] vertex_c_x;
        logic signed [COORD_BITS-1:0] vertex_c_y;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_in;

    // one answer
    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_out;

    // edge vectors u = b-a, v = c-a, w = p-a
    typedef struct packed {
        logic signed [DIFF_W-1:0] ux;
        logic signed [DIFF_W-1:0] uy;
        logic signed [DIFF_W-1:0] vx;
        logic signed [DIFF_W-1:0] vy;
        logic signed [DIFF_W-1:0] wx;
        logic signed [DIFF_W-1:0] wy;
    } t_edge;

    // the six partial products of the three cross products
    typedef struct packed {
        logic signed [PROD_W-1:0] ux_vy;
        logic signed [PROD_W-1:0] uy_vx;
        logic signed [PROD_W-1:0] wx_vy;
        logic signed [PROD_W-1:0] wy_vx;
        logic signed [PROD_W-1:0] ux_wy;
        logic signed [PROD_W-1:0] uy_wx;
    } t_prod;

    // cross(u,v), cross(w,v), cross(u,w)
    typedef struct packed {
        logic signed [CROSS_W-1:0] d;
        logic signed [CROSS_W-1:0] sn;
        logic signed [CROSS_W-1:0] tn;
    } t_cross;

    // numerators after forcing the denominator positive
    typedef struct packed {
        logic                      degen;
        logic signed [CROSS_W-1:0] d_abs;
        logic signed [CROSS_W-1:0] sn;
        logic signed [CROSS_W-1:0] tn;
    } t_norm;

endpackage

/* rtl/point_in_triangle_test_core.sv */
// an input transfer passes the edge, product, cross, normalize and output registers to o_valid/o_data
// throughput: one query per cycle while i_stall is low; bubbles collapse under output stall
// each of the 5 register stages holds one item; the 17x17 multiplies set the stage depth
// reset (i_rst_n low, synchronous) clears every stage valid bit; no memories
// top level of the point-in-triangle test pipeline
module point_in_triangle_test_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  pit_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output pit_pkg::t_out o_data
);

    logic            edge_valid;
    logic            edge_stall;
    pit_pkg::t_edge  edge_data;
    logic            cross_valid;
    logic            cross_stall;
    pit_pkg::t_cross cross_data;

    // edge vectors
    pit_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (edge_valid),
        .i_stall (edge_stall),
        .o_data  (edge_data)
    );

    // cross products
    pit_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (edge_valid),
        .o_stall (edge_stall),
        .i_data  (edge_data),
        .o_valid (cross_valid),
        .i_stall (cross_stall),
        .o_data  (cross_data)
    );

    // sign tests and output register
    pit_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cross_valid),
        .o_stall (cross_stall),
        .i_data  (cross_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

/* rtl/pit_edge.sv */
// stage 1: edge vectors relative to vertex a
module pit_edge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pit_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output pit_pkg::t_edge o_data
);

    logic           adv;
    logic           r_valid;
    pit_pkg::t_edge r_edge;
    pit_pkg::t_edge n_edge;

    // stage moves when empty or when its contents leave
    assign adv     = !r_valid || !i_stall;
    assign o_stall = !adv;

    // coordinate differences, one bit wider
    always_comb begin
        n_edge.ux = pit_pkg::DIFF_W'(i_data.vertex_b_x) - pit_pkg::DIFF_W'(i_data.vertex_a_x);
        n_edge.uy = pit_pkg::DIFF_W'(i_data.vertex_b_y) - pit_pkg::DIFF_W'(i_data.vertex_a_y);
        n_edge.vx = pit_pkg::DIFF_W'(i_data.vertex_c_x) - pit_pkg::DIFF_W'(i_data.vertex_a_x);
        n_edge.vy = pit_pkg::DIFF_W'(i_data.vertex_c_y) - pit_pkg::DIFF_W'(i_data.vertex_a_y);
        n_edge.wx = pit_pkg::DIFF_W'(i_data.point_x) - pit_pkg::DIFF_W'(i_data.vertex_a_x);
        n_edge.wy = pit_pkg::DIFF_W'(i_data.point_y) - pit_pkg::DIFF_W'(i_data.vertex_a_y);
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_edge <= n_edge;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_edge;

endmodule

/* rtl/pit_cross.sv */
// stages 2 and 3: partial products, then the three cross products
module pit_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pit_pkg::t_edge  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output pit_pkg::t_cross o_data
);

    logic            adv_prod;
    logic            adv_cross;
    logic            r_prod_valid;
    logic            r_cross_valid;
    pit_pkg::t_prod  r_prod;
    pit_pkg::t_prod  n_prod;
    pit_pkg::t_cross r_cross;
    pit_pkg::t_cross n_cross;

    // per-stage advance, bubbles collapse
    assign adv_cross = !r_cross_valid || !i_stall;
    assign adv_prod  = !r_prod_valid || adv_cross;
    assign o_stall   = !adv_prod;

    // six narrow multipliers
    always_comb begin
        n_prod.ux_vy = pit_pkg::PROD_W'(i_data.ux) * pit_pkg::PROD_W'(i_data.vy);
        n_prod.uy_vx = pit_pkg::PROD_W'(i_data.uy) * pit_pkg::PROD_W'(i_data.vx);
        n_prod.wx_vy = pit_pkg::PROD_W'(i_data.wx) * pit_pkg::PROD_W'(i_data.vy);
        n_prod.wy_vx = pit_pkg::PROD_W'(i_data.wy) * pit_pkg::PROD_W'(i_data.vx);
        n_prod.ux_wy = pit_pkg::PROD_W'(i_data.ux) * pit_pkg::PROD_W'(i_data.wy);
        n_prod.uy_wx = pit_pkg::PROD_W'(i_data.uy) * pit_pkg::PROD_W'(i_data.wx);
    end

    // cross products from registered partials
    always_comb begin
        n_cross.d  = pit_pkg::CROSS_W'(r_prod.ux_vy) - pit_pkg::CROSS_W'(r_prod.uy_vx);
        n_cross.sn = pit_pkg::CROSS_W'(r_prod.wx_vy) - pit_pkg::CROSS_W'(r_prod.wy_vx);
        n_cross.tn = pit_pkg::CROSS_W'(r_prod.ux_wy) - pit_pkg::CROSS_W'(r_prod.uy_wx);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid  <= 1'b0;
            r_cross_valid <= 1'b0;
        end else begin
            if (adv_prod) begin
                r_prod_valid <= i_valid;
            end
            if (adv_cross) begin
                r_cross_valid <= r_prod_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv_prod && i_valid) begin
            r_prod <= n_prod;
        end
        if (adv_cross && r_prod_valid) begin
            r_cross <= n_cross;
        end
    end

    assign o_valid = r_cross_valid;
    assign o_data  = r_cross;

endmodule

/* rtl/pit_decide.sv */
// stages 4 and 5: sign normalize, then the range compare into the output register
`include "point_in_triangle_test_core_assert.svh"

module pit_decide (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  pit_pkg::t_cross i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output pit_pkg::t_out   o_data
);

    logic                            adv_norm;
    logic                            adv_out;
    logic                            r_norm_valid;
    logic                            r_out_valid;
    pit_pkg::t_norm                  r_norm;
    pit_pkg::t_norm                  n_norm;
    pit_pkg::t_out                   r_out;
    pit_pkg::t_out                   n_out;
    logic signed [pit_pkg::SUM_W-1:0] sum_st;

    // per-stage advance
    assign adv_out  = !r_out_valid || !i_stall;
    assign adv_norm = !r_norm_valid || adv_out;
    assign o_stall  = !adv_norm;

    // flip all three signs when the denominator is negative
    always_comb begin
        n_norm.degen = (i_data.d == '0);
        if (i_data.d[pit_pkg::CROSS_W-1]) begin
            n_norm.d_abs = -i_data.d;
            n_norm.sn    = -i_data.sn;
            n_norm.tn    = -i_data.tn;
        end else begin
            n_norm.d_abs = i_data.d;
            n_norm.sn    = i_data.sn;
            n_norm.tn    = i_data.tn;
        end
    end

    // not degenerate, s >= 0, t >= 0 and s + t <= 1, scaled by the denominator
    always_comb begin
        sum_st = pit_pkg::SUM_W'(r_norm.sn) + pit_pkg::SUM_W'(r_norm.tn);
        n_out.degenerate = r_norm.degen;
        n_out.inside_res = !r_norm.degen
                        && !r_norm.sn[pit_pkg::CROSS_W-1]
                        && !r_norm.tn[pit_pkg::CROSS_W-1]
                        && (sum_st <= pit_pkg::SUM_W'(r_norm.d_abs));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (adv_norm) begin
                r_norm_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_norm_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv_norm && i_valid) begin
            r_norm <= n_norm;
        end
        if (adv_out && r_norm_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // normalized denominator is never negative
    `PIT_ASSERT_NOW(a_dabs_nonneg, i_clk, i_rst_n, r_norm_valid, !r_norm.d_abs[pit_pkg::CROSS_W-1])
    // degenerate flag matches a zero denominator
    `PIT_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, r_norm_valid, r_norm.degen == (r_norm.d_abs == '0))
    // a degenerate triangle never reports inside
    `PIT_ASSERT_NOW(a_degen_out, i_clk, i_rst_n, r_out_valid, !(r_out.degenerate && r_out.inside_res))
    // a staged item reaches the output register on the next edge when it is free
    `PIT_ASSERT_NEXT(a_norm_moves, i_clk, i_rst_n, r_norm_valid && !r_out_valid, r_out_valid)

endmodule
